@@ sv/acb_pkg.sv @@
// ----------------------------------------------------------------------------
// acb_pkg
// Shared types and constants for the age class bitmap unit.
// ----------------------------------------------------------------------------
package acb_pkg;

    localparam int DEF_NUM_CLASSES = 64;
    localparam int MAX_CLASSES     = 64;

    localparam int MODE_W  = 3;
    localparam int AGE_W   = 10;
    localparam int COUNT_W = 7;

    // age / 10 == (age * 205) >> 11, exact for every 10-bit age
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_MUL_W = 8;
    localparam int DIV10_SHIFT = 11;
    localparam int PROD_W      = AGE_W + DIV10_MUL_W;
    localparam int Q_W         = PROD_W - DIV10_SHIFT;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY     = 3'd0,
        MODE_SET       = 3'd1,
        MODE_CLEAR     = 3'd2,
        MODE_SHIFT     = 3'd3,
        MODE_CLEAR_ALL = 3'd4
    } t_mode;

    typedef struct packed {
        logic               any;
        logic [AGE_W-1:0]   youngest;
        logic [AGE_W-1:0]   oldest;
        logic [COUNT_W-1:0] count;
    } t_report;

endpackage

@@ sv/age_class_bitmap_unit.sv @@
// ----------------------------------------------------------------------------
// age_class_bitmap_unit
// Ten-year age class map with set/clear/shift/clear-all updates and queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction of mode,
//   age, range_low and range_high. Each transaction first updates the class
//   map, then yields one result transaction on the output channel
//   (o_out_valid / i_out_stall) describing the updated map.
//   Timing: an accepted transaction is registered in the input register,
//   processed and presented on the outputs from the result register.
//   Throughput: one transaction per cycle while no result is held by
//   i_out_stall; the map update and all queries are resolved in the single
//   stage between the input and result registers, so each item sees the map left by the previous one.
//   Stall: while a result is held by i_out_stall, the item in the input
//   register waits and o_in_stall rises; nothing is dropped.
//   Reset: i_rst_n low clears the map to empty and empties both registers.
//   Illegal ages or an inverted range set o_illegal and leave the map as is.
// ----------------------------------------------------------------------------
module age_class_bitmap_unit
    import acb_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [AGE_W-1:0]   i_age,
    input  logic [AGE_W-1:0]   i_range_low,
    input  logic [AGE_W-1:0]   i_range_high,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_any_present,
    output logic               o_age_present,
    output logic               o_range_present,
    output logic [AGE_W-1:0]   o_youngest_age,
    output logic [AGE_W-1:0]   o_oldest_age,
    output logic [COUNT_W-1:0] o_class_count,
    output logic               o_illegal
);

    localparam int CW = $clog2(NUM_CLASSES);

    logic                   r_in_valid;
    t_mode                  r_mode;
    logic [AGE_W-1:0]       r_age;
    logic [AGE_W-1:0]       r_lo;
    logic [AGE_W-1:0]       r_hi;

    logic [NUM_CLASSES-1:0] r_map;
    logic [NUM_CLASSES-1:0] n_map;

    logic                   r_out_valid;
    logic                   r_any;
    logic                   r_age_hit;
    logic                   r_range_hit;
    logic [AGE_W-1:0]       r_young;
    logic [AGE_W-1:0]       r_old;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_illegal;

    logic                   advance;
    logic                   fire;
    logic                   age_ok;
    logic                   lo_ok;
    logic                   hi_ok;
    logic [CW-1:0]          age_cls;
    logic [CW-1:0]          lo_cls;
    logic [CW-1:0]          hi_cls;
    logic                   range_ok;
    logic                   illegal;
    logic [NUM_CLASSES-1:0] abit;
    logic [NUM_CLASSES-1:0] range_mask;
    t_report                report;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_mode <= t_mode'(i_mode);
            r_age  <= i_age;
            r_lo   <= i_range_low;
            r_hi   <= i_range_high;
        end
    end

    acb_class_decode #(.NUM_CLASSES(NUM_CLASSES), .CW(CW)) u_dec_age (
        .i_age   (r_age),
        .o_ok    (age_ok),
        .o_class (age_cls)
    );

    acb_class_decode #(.NUM_CLASSES(NUM_CLASSES), .CW(CW)) u_dec_lo (
        .i_age   (r_lo),
        .o_ok    (lo_ok),
        .o_class (lo_cls)
    );

    acb_class_decode #(.NUM_CLASSES(NUM_CLASSES), .CW(CW)) u_dec_hi (
        .i_age   (r_hi),
        .o_ok    (hi_ok),
        .o_class (hi_cls)
    );

    assign range_ok = lo_ok && hi_ok && (lo_cls <= hi_cls);
    assign illegal  = !age_ok || !range_ok;
    assign abit     = NUM_CLASSES'(1) << age_cls;

    always_comb begin
        n_map = r_map;
        if (!illegal) begin
            case (r_mode)
                MODE_SET:       n_map = r_map | abit;
                MODE_CLEAR:     n_map = r_map & ~abit;
                MODE_SHIFT:     n_map = {r_map[NUM_CLASSES-2:0], 1'b0};
                MODE_CLEAR_ALL: n_map = '0;
                default:        n_map = r_map;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            range_mask[i] = (CW'(i) >= lo_cls) && (CW'(i) <= hi_cls);
        end
    end

    acb_map_report #(.NUM_CLASSES(NUM_CLASSES), .CW(CW)) u_report (
        .i_map    (n_map),
        .o_report (report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_map <= n_map;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_any       <= report.any;
            r_age_hit   <= age_ok && ((n_map & abit) != '0);
            r_range_hit <= range_ok && ((n_map & range_mask) != '0);
            r_young     <= report.youngest;
            r_old       <= report.oldest;
            r_count     <= report.count;
            r_illegal   <= illegal;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_any_present   = r_any;
    assign o_age_present   = r_age_hit;
    assign o_range_present = r_range_hit;
    assign o_youngest_age  = r_young;
    assign o_oldest_age    = r_old;
    assign o_class_count   = r_count;
    assign o_illegal       = r_illegal;

    a_map_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_map))
        else $error("class map changed without a transaction");

    a_illegal_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && illegal) |=> (r_map == $past(r_map)))
        else $error("illegal transaction updated the class map");

    a_count_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_any_present == (o_class_count != '0)))
        else $error("class count disagrees with any_present");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_any_present) |-> (o_youngest_age <= o_oldest_age))
        else $error("youngest age above oldest age");

    a_hit_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_age_present || o_range_present)) |-> o_any_present)
        else $error("query hit on an empty map");

endmodule

@@ sv/acb_class_decode.sv @@
// ----------------------------------------------------------------------------
// acb_class_decode
// Converts an age in years to a class index (age/10 - 1) and flags
// whether that class lies inside the map.
// ----------------------------------------------------------------------------
module acb_class_decode
    import acb_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int CW          = $clog2(NUM_CLASSES)
) (
    input  logic [AGE_W-1:0] i_age,
    output logic             o_ok,
    output logic [CW-1:0]    o_class
);

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    quot;
    logic [Q_W-1:0]    quot_m1;

    assign prod    = PROD_W'(i_age) * PROD_W'(DIV10_MUL);
    assign quot    = prod[PROD_W-1:DIV10_SHIFT];
    assign quot_m1 = quot - Q_W'(1);
    assign o_ok    = (quot != '0) && (quot <= Q_W'(NUM_CLASSES));
    assign o_class = quot_m1[CW-1:0];

endmodule

@@ sv/acb_map_report.sv @@
// ----------------------------------------------------------------------------
// acb_map_report
// Summary of the class map: any present, youngest and oldest present age,
// and the number of present classes.
// ----------------------------------------------------------------------------
module acb_map_report
    import acb_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int CW          = $clog2(NUM_CLASSES)
) (
    input  logic [NUM_CLASSES-1:0] i_map,
    output t_report                o_report
);

    logic [NUM_CLASSES-1:0] rev_map;
    logic [NUM_CLASSES-1:0] low_oh;
    logic [NUM_CLASSES-1:0] high_oh;
    logic [CW-1:0]          low_idx;
    logic [CW-1:0]          high_rev_idx;
    logic [CW-1:0]          high_idx;
    logic [AGE_W-1:0]       low_step;
    logic [AGE_W-1:0]       high_step;
    logic                   any;

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            rev_map[i] = i_map[NUM_CLASSES-1-i];
        end
    end

    assign low_oh  = i_map & (~i_map + NUM_CLASSES'(1));
    assign high_oh = rev_map & (~rev_map + NUM_CLASSES'(1));

    always_comb begin
        low_idx      = '0;
        high_rev_idx = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (low_oh[i]) begin
                low_idx = low_idx | CW'(i);
            end
            if (high_oh[i]) begin
                high_rev_idx = high_rev_idx | CW'(i);
            end
        end
    end

    assign high_idx  = CW'(NUM_CLASSES - 1) - high_rev_idx;
    assign low_step  = AGE_W'(low_idx) + AGE_W'(1);
    assign high_step = AGE_W'(high_idx) + AGE_W'(1);
    assign any       = |i_map;

    // (idx + 1) * 10 as shift-and-add
    always_comb begin
        o_report.any      = any;
        o_report.youngest = any ? (low_step << 3) + (low_step << 1) : '0;
        o_report.oldest   = any ? (high_step << 3) + (high_step << 1) : '0;
        o_report.count    = COUNT_W'($countones(i_map));
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for age_class_bitmap_unit. A table of directed
// transactions covers the age and range limits, the illegal cases and every
// mode. Random phases with fill sweeps, well-formed and noise transactions
// follow under varied sender idling and receiver stalls. Each result is
// checked against its table value or an in-bench model of the class map.
// ----------------------------------------------------------------------------
module tb
    import acb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS           = DEF_NUM_CLASSES;
    localparam int RAND_PER_PHASE = 375;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int LONG_HOLD      = 60;

    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic               any;
        logic               age_hit;
        logic               range_hit;
        logic [AGE_W-1:0]   youngest;
        logic [AGE_W-1:0]   oldest;
        logic [COUNT_W-1:0] count;
        logic               illegal;
    } t_age_report;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [AGE_W-1:0]  age;
        logic [AGE_W-1:0]  lo;
        logic [AGE_W-1:0]  hi;
        logic              typed;
        t_age_report       want;
    } t_dir_row;

    localparam t_age_report EMPTY_OK  = '0;
    localparam t_age_report EMPTY_BAD = '{1'b0, 1'b0, 1'b0, 10'd0, 10'd0, 7'd0, 1'b1};
    localparam t_age_report TWO_ENDS  = '{1'b1, 1'b1, 1'b1, 10'd10, 10'd640, 7'd2, 1'b0};

    localparam int N_DIR = 24;
    localparam t_dir_row DIR_TBL [N_DIR] = '{
        '{MODE_QUERY,     10'd10,   10'd10,  10'd649,  1'b1, EMPTY_OK},
        '{MODE_SET,       10'd0,    10'd10,  10'd20,   1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd9,    10'd10,  10'd20,   1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd650,  10'd10,  10'd20,   1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd1023, 10'd10,  10'd20,   1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd100,  10'd9,   10'd20,   1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd100,  10'd10,  10'd650,  1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd100,  10'd0,   10'd1023, 1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd100,  10'd200, 10'd100,  1'b1, EMPTY_BAD},
        '{MODE_SET,       10'd10,   10'd25,  10'd21,   1'b0, EMPTY_OK},
        '{MODE_SET,       10'd649,  10'd10,  10'd649,  1'b0, EMPTY_OK},
        '{MODE_QUERY,     10'd645,  10'd10,  10'd649,  1'b1, TWO_ENDS},
        '{MODE_QUERY,     10'd19,   10'd640, 10'd649,  1'b0, EMPTY_OK},
        '{MODE_SHIFT,     10'd10,   10'd10,  10'd10,   1'b0, EMPTY_OK},
        '{MODE_QUERY,     10'd10,   10'd10,  10'd19,   1'b0, EMPTY_OK},
        '{MODE_CLEAR,     10'd20,   10'd10,  10'd649,  1'b0, EMPTY_OK},
        '{MODE_SPARE_5,   10'd500,  10'd10,  10'd649,  1'b0, EMPTY_OK},
        '{MODE_SPARE_6,   10'd510,  10'd500, 10'd519,  1'b0, EMPTY_OK},
        '{MODE_SPARE_7,   10'd520,  10'd10,  10'd649,  1'b0, EMPTY_OK},
        '{MODE_SET,       10'd333,  10'd330, 10'd339,  1'b0, EMPTY_OK},
        '{MODE_CLEAR_ALL, 10'd1023, 10'd10,  10'd649,  1'b0, EMPTY_OK},
        '{MODE_CLEAR_ALL, 10'd10,   10'd10,  10'd649,  1'b1, EMPTY_OK},
        '{MODE_SHIFT,     10'd10,   10'd10,  10'd649,  1'b1, EMPTY_OK},
        '{MODE_CLEAR,     10'd50,   10'd10,  10'd649,  1'b1, EMPTY_OK}
    };

    localparam int TX_IDLE_PCT  [4] = '{0, 60, 0, 10};
    localparam int RX_STALL_PCT [4] = '{0, 0, 60, 10};

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [MODE_W-1:0]  txn_mode;
    logic [AGE_W-1:0]   txn_age;
    logic [AGE_W-1:0]   txn_lo;
    logic [AGE_W-1:0]   txn_hi;
    logic               out_valid;
    logic               out_stall;
    t_age_report        got;

    logic [MAX_CLASSES-1:0] class_map;
    t_age_report            pending_reports [$];
    int                     fail_cnt;
    int                     cycle_cnt;
    int                     tx_idle_pct;
    int                     rx_stall_pct;
    bit                     hold_arm;

    age_class_bitmap_unit #(.NUM_CLASSES(NCLS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (txn_mode),
        .i_age          (txn_age),
        .i_range_low    (txn_lo),
        .i_range_high   (txn_hi),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_any_present  (got.any),
        .o_age_present  (got.age_hit),
        .o_range_present(got.range_hit),
        .o_youngest_age (got.youngest),
        .o_oldest_age   (got.oldest),
        .o_class_count  (got.count),
        .o_illegal      (got.illegal)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one update to the class map and returns the report on the new map.
    function automatic t_age_report update_class_map(logic [MODE_W-1:0] m,
                                                     logic [AGE_W-1:0] a,
                                                     logic [AGE_W-1:0] lo,
                                                     logic [AGE_W-1:0] hi);
        int unsigned            ac;
        int unsigned            lc;
        int unsigned            hc;
        bit                     a_ok;
        bit                     lo_ok;
        bit                     hi_ok;
        bit                     rng_ok;
        bit                     bad;
        logic [MAX_CLASSES-1:0] mask;
        logic [MAX_CLASSES-1:0] bm;
        t_age_report            r;
        ac     = a / 10;
        lc     = lo / 10;
        hc     = hi / 10;
        a_ok   = (ac != 0) && (ac <= NCLS);
        lo_ok  = (lc != 0) && (lc <= NCLS);
        hi_ok  = (hc != 0) && (hc <= NCLS);
        ac     = a_ok  ? ac - 1 : 0;
        lc     = lo_ok ? lc - 1 : 0;
        hc     = hi_ok ? hc - 1 : 0;
        rng_ok = lo_ok && hi_ok && (lc <= hc);
        bad    = !a_ok || !rng_ok;
        mask   = (NCLS >= MAX_CLASSES) ? '1 : ((MAX_CLASSES'(1) << NCLS) - 1);
        bm     = class_map & mask;
        if (!bad) begin
            case (m)
                MODE_SET:       bm[ac] = 1'b1;
                MODE_CLEAR:     bm[ac] = 1'b0;
                MODE_SHIFT:     bm = (bm << 1) & mask;
                MODE_CLEAR_ALL: bm = '0;
                default: ;
            endcase
        end
        class_map = bm;
        r         = '0;
        r.illegal = bad;
        r.any     = |bm;
        r.age_hit = a_ok && bm[ac];
        for (int i = 0; i < NCLS; i++) begin
            if (bm[i]) begin
                r.count++;
                if (r.youngest == 0) r.youngest = AGE_W'((i + 1) * 10);
                r.oldest = AGE_W'((i + 1) * 10);
                if (rng_ok && i >= lc && i <= hc) r.range_hit = 1'b1;
            end
        end
        return r;
    endfunction

    // Entered at a falling edge; returns at the falling edge after acceptance.
    task automatic send_txn(logic [MODE_W-1:0] m, logic [AGE_W-1:0] a,
                            logic [AGE_W-1:0] lo, logic [AGE_W-1:0] hi,
                            logic typed, t_age_report want);
        t_age_report predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        txn_mode <= m;
        txn_age  <= a;
        txn_lo   <= lo;
        txn_hi   <= hi;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predicted = update_class_map(m, a, lo, hi);
        pending_reports.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_txn();
        logic [MODE_W-1:0] m;
        logic [AGE_W-1:0]  a;
        logic [AGE_W-1:0]  lo;
        logic [AGE_W-1:0]  hi;
        int                pick;
        if ($urandom_range(0, 99) < 15) begin
            m  = MODE_W'($urandom_range(0, 7));
            a  = AGE_W'($urandom_range(0, 1023));
            lo = AGE_W'($urandom_range(0, 1023));
            hi = AGE_W'($urandom_range(0, 1023));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      m = MODE_SET;
            else if (pick < 55) m = MODE_CLEAR;
            else if (pick < 65) m = MODE_SHIFT;
            else if (pick < 68) m = MODE_CLEAR_ALL;
            else if (pick < 90) m = MODE_QUERY;
            else                m = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
            a  = AGE_W'($urandom_range(10, 649));
            lo = AGE_W'($urandom_range(10, 649));
            if ($urandom_range(0, 1) == 1) hi = AGE_W'($urandom_range(lo, 649));
            else hi = AGE_W'((lo + $urandom_range(0, 40) > 649) ? 649
                                                                 : lo + $urandom_range(0, 40));
        end
        send_txn(m, a, lo, hi, 1'b0, '0);
    endtask

    // receiver stall generation, with one long hold-off
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_arm && !hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = 1;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_age_report want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                if (fail_cnt < 10)
                    $display("unexpected result transaction: %p", got);
                fail_cnt++;
            end else begin
                want = pending_reports.pop_front();
                if (got.any !== want.any || got.age_hit !== want.age_hit ||
                    got.range_hit !== want.range_hit || got.youngest !== want.youngest ||
                    got.oldest !== want.oldest || got.count !== want.count ||
                    got.illegal !== want.illegal) begin
                    if (fail_cnt < 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("age_class_bitmap_unit regression: fail");
            $finish;
        end
    end

    initial begin
        fail_cnt     = 0;
        cycle_cnt    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_arm     = 0;
        class_map    = '0;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        txn_mode     = MODE_QUERY;
        txn_age      = '0;
        txn_lo       = '0;
        txn_hi       = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++)
            send_txn(DIR_TBL[r].mode, DIR_TBL[r].age, DIR_TBL[r].lo, DIR_TBL[r].hi,
                     DIR_TBL[r].typed, DIR_TBL[r].want);
        drain_reports();

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = TX_IDLE_PCT[ph];
            rx_stall_pct = RX_STALL_PCT[ph];
            if (ph == 0) hold_arm = 1;
            // fill every class so the map reaches full
            for (int k = 0; k < NCLS; k++)
                send_txn(MODE_SET, AGE_W'((k + 1) * 10 + $urandom_range(0, 9)),
                         AGE_W'($urandom_range(10, 329)), AGE_W'($urandom_range(330, 649)),
                         1'b0, '0);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_random_txn();
            drain_reports();
        end

        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("age_class_bitmap_unit regression: pass");
        end else begin
            $display("age_class_bitmap_unit regression: fail");
        end
        $finish;
    end

endmodule
